>>> rtl/bthal_pkg.sv
package bthal_pkg;

   localparam int HEAP_BYTES = 65536;
   localparam int PAGE_BYTES = 4096;
   localparam int ALIGN_BYTES = 16;
   localparam int OVERHEAD = 32;
   localparam int MIN_BLOCK = 48;
   localparam int WORDS = HEAP_BYTES / 8;
   localparam int WALK_MAX = HEAP_BYTES / 48 + 1;
   localparam int MAX_PAGES = HEAP_BYTES / PAGE_BYTES;

   localparam int OFF_W = $clog2(HEAP_BYTES) + 1;
   localparam int ADDR_W = OFF_W + 1;
   localparam int IDX_W = $clog2(WORDS);
   localparam int STEP_W = $clog2(WALK_MAX + 1);
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int PAGE_W = 5;
   localparam int BLK_W = 13;

   localparam logic [OFF_W-1:0] NIL = OFF_W'(HEAP_BYTES);
   localparam logic [PAGE_W-1:0] RESET_LIMIT = PAGE_W'(16);

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_NULL = 3'd1;
   localparam logic [2:0] ST_TOO_LARGE = 3'd2;
   localparam logic [2:0] ST_EXHAUSTED = 3'd3;
   localparam logic [2:0] ST_BAD_PTR = 3'd4;
   localparam logic [2:0] ST_DOUBLE = 3'd5;
   localparam logic [2:0] ST_CORRUPT = 3'd6;

   typedef enum logic [5:0] {
      S_CLEAR, S_IDLE, S_DONE,
      S_WALK, S_WALK_CHK, S_WALK_NEXT,
      S_SPLIT, S_SPLIT_REST, S_SPLIT_LINK, S_ALLOC_RD, S_ALLOC_FIN,
      S_GROW, S_GROW_RD, S_GROW_TAIL, S_GROW_UNLINK, S_GROW_PUT, S_GROW_LINK, S_GROW_DONE,
      S_REL_CHK, S_REL_NEXT, S_REL_NCHK, S_REL_NRD, S_REL_NSUM, S_REL_PREV, S_REL_PTAG,
      S_REL_PUNLINK, S_REL_PPUT, S_REL_LINK, S_REL_DONE,
      S_CHK_HDR, S_CHK_TAG, S_CHK_FTR,
      S_UL_P, S_UL_N, S_UL_FIX, S_UL_NFIX, S_UL_CLRP, S_UL_CLRN, S_UL_RD, S_UL_SUM,
      S_LK_P, S_LK_N, S_LK_HEAD, S_LK_RD, S_LK_SUM,
      S_PUT_HDR, S_PUT_FTR
   } state_type;

   // Size part of a tag word: the flag nibble masked off.
   function automatic logic [OFF_W-1:0] tag_size(input logic [OFF_W-1:0] t);
      tag_size = {t[OFF_W-1:4], 4'b0000};
   endfunction

   // Contents of a tag word right after reset: one free page at offset 0.
   function automatic logic [OFF_W-1:0] init_word(input logic [IDX_W-1:0] idx);
      logic [OFF_W-1:0] page_tag;
      page_tag = OFF_W'(PAGE_BYTES + 1);
      if (idx == IDX_W'(0) || idx == IDX_W'(PAGE_BYTES / 8 - 1)) begin
         init_word = page_tag;
      end else if (idx == IDX_W'(1) || idx == IDX_W'(2)) begin
         init_word = NIL;
      end else begin
         init_word = '0;
      end
   endfunction

endpackage

>>> rtl/bthal_ram.sv
module bthal_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

>>> rtl/boundary_tag_heap_allocator.sv
// An allocate walks the free list first fit and grows the heap by whole pages when no block
// fits; a release merges the freed block with free neighbors on both sides.
// Throughput: one item at a time; the single port of the tag memory sets the pace.
// Reset: synchronous, active high; afterwards a clearing pass writes every tag word while
// no item is accepted. Configuration writes are taken throughout.
module boundary_tag_heap_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: request_bytes [15:0], release_offset [31:16]
   input  logic [31:0] req_tdata,
   // tuser: mode [0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: status [2:0], payload_offset [18:3], blocks_in_use [31:19],
   // bytes_in_use [48:32], bytes_free [65:49], pages_mapped [70:66], zero pad [71]
   output logic [71:0] rsp_tdata,
   input  logic        csr_wen,
   input  logic [4:0]  csr_wdata
);
   import bthal_pkg::*;

   // Sequencer state and the return point of the shared subroutines
   // (tag check, unlink, link, block write).
   state_type state_ff, state_in, ret_ff, ret_in;
   logic [IDX_W-1:0] clr_ff, clr_in;

   // Allocator state kept in flip-flops.
   logic [PAGE_W-1:0] limit_ff, limit_in;
   logic [OFF_W-1:0]  free_head_ff, free_head_in;
   logic [OFF_W-1:0]  heap_end_ff, heap_end_in;
   logic [BLK_W-1:0]  blocks_ff, blocks_in;
   logic [OFF_W-1:0]  used_ff, used_in;
   logic [OFF_W-1:0]  free_ff, free_in;
   logic [PAGE_W-1:0] pages_ff, pages_in;
   logic [2:0]        halt_ff, halt_in;

   // Working registers of the item in flight.
   logic [OFF_W-1:0]  b_ff, b_in;
   logic [OFF_W-1:0]  size_ff, size_in;
   logic [OFF_W-1:0]  need_ff, need_in;
   logic [OFF_W-1:0]  orig_ff, orig_in;
   logic [OFF_W-1:0]  old_ff, old_in;
   logic [OFF_W-1:0]  grow_ff, grow_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic              pass_ff, pass_in;
   logic [OFF_W-1:0]  ca_ff, ca_in;
   logic [OFF_W-1:0]  tag_ff, tag_in;
   logic [OFF_W-1:0]  la_ff, la_in;
   logic [OFF_W-1:0]  lp_ff, lp_in;
   logic [OFF_W-1:0]  ln_ff, ln_in;
   logic [OFF_W-1:0]  pa_ff, pa_in;
   logic [OFF_W-1:0]  psz_ff, psz_in;
   logic              pfree_ff, pfree_in;
   logic [2:0]        st_ff, st_in;
   logic [15:0]       pay_ff, pay_in;

   // Result register that decouples the sequencer from the consumer.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [71:0] rsp_data_ff, rsp_data_in;

   // Tag memory port. Offsets beyond the store drop writes and read as zero.
   logic [ADDR_W-1:0] mem_off;
   logic              mem_we;
   logic [OFF_W-1:0]  mem_wd;
   logic [OFF_W-1:0]  mem_q;
   logic [OFF_W-1:0]  mem_rd;
   logic              mem_hit;
   logic              oob_ff;

   assign mem_hit = (mem_off[ADDR_W-1:ADDR_W-2] == 2'b00);
   assign mem_rd = oob_ff ? '0 : mem_q;

   bthal_ram #(.WIDTH(OFF_W), .DEPTH(WORDS)) u_tags (
      .clock (clock),
      .we    (mem_we && mem_hit),
      .addr  (mem_off[IDX_W+2:3]),
      .wdata (mem_wd),
      .rdata (mem_q)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   always_comb begin
      logic [2:0]        fail_c;
      logic [OFF_W-1:0]  sz;
      logic [ADDR_W-1:0] sum_a;
      logic [ADDR_W-1:0] lim_b;
      logic [PAGE_W:0]   add_pg;
      logic [OFF_W-1:0]  req_b;
      logic [OFF_W-1:0]  rel_p;
      logic [OFF_W-1:0]  need_c;

      fail_c = ST_OK;
      sz = '0;
      sum_a = '0;
      lim_b = '0;
      add_pg = '0;
      req_b = {1'b0, req_tdata[15:0]};
      rel_p = {1'b0, req_tdata[31:16]};
      need_c = '0;

      state_in = state_ff;
      ret_in = ret_ff;
      clr_in = clr_ff;
      limit_in = csr_wen ? csr_wdata : limit_ff;
      free_head_in = free_head_ff;
      heap_end_in = heap_end_ff;
      blocks_in = blocks_ff;
      used_in = used_ff;
      free_in = free_ff;
      pages_in = pages_ff;
      halt_in = halt_ff;
      b_in = b_ff;
      size_in = size_ff;
      need_in = need_ff;
      orig_in = orig_ff;
      old_in = old_ff;
      grow_in = grow_ff;
      steps_in = steps_ff;
      pass_in = pass_ff;
      ca_in = ca_ff;
      tag_in = tag_ff;
      la_in = la_ff;
      lp_in = lp_ff;
      ln_in = ln_ff;
      pa_in = pa_ff;
      psz_in = psz_ff;
      pfree_in = pfree_ff;
      st_in = st_ff;
      pay_in = pay_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      mem_off = '0;
      mem_we = 1'b0;
      mem_wd = '0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_off = {2'b00, clr_ff, 3'b000};
            mem_we = 1'b1;
            mem_wd = init_word(clr_ff);
            clr_in = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_tvalid) begin
               pay_in = '0;
               steps_in = '0;
               pass_in = 1'b0;
               st_in = ST_OK;
               if (halt_ff != ST_OK) begin
                  st_in = halt_ff;
                  state_in = S_DONE;
               end else if (!req_tuser) begin
                  need_c = (req_b + OFF_W'(OVERHEAD + ALIGN_BYTES - 1)) & ~OFF_W'(ALIGN_BYTES - 1);
                  if (req_b == '0) begin
                     st_in = ST_NULL;
                     state_in = S_DONE;
                  end else if (req_b > OFF_W'(HEAP_BYTES - OVERHEAD)) begin
                     fail_c = ST_TOO_LARGE;
                  end else begin
                     need_in = (need_c < OFF_W'(MIN_BLOCK)) ? OFF_W'(MIN_BLOCK) : need_c;
                     b_in = free_head_ff;
                     state_in = S_WALK;
                  end
               end else begin
                  if (rel_p == '0) begin
                     state_in = S_DONE;
                  end else if (rel_p < OFF_W'(24) || rel_p >= heap_end_ff ||
                               rel_p[3:0] != 4'd8) begin
                     fail_c = ST_BAD_PTR;
                  end else begin
                     b_in = rel_p - OFF_W'(24);
                     ca_in = rel_p - OFF_W'(24);
                     ret_in = S_REL_CHK;
                     state_in = S_CHK_HDR;
                  end
               end
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {1'b0, pages_ff, free_ff, used_ff, blocks_ff, pay_ff, st_ff};
               state_in = S_IDLE;
            end
         end

         // First-fit walk over the free list.
         S_WALK: begin
            if (b_ff[OFF_W-1]) begin
               if (!pass_ff) begin
                  state_in = S_GROW;
               end else begin
                  fail_c = ST_CORRUPT;
               end
            end else if (steps_ff >= STEP_W'(WALK_MAX)) begin
               fail_c = ST_CORRUPT;
            end else begin
               steps_in = steps_ff + 1'b1;
               ca_in = b_ff;
               ret_in = S_WALK_CHK;
               state_in = S_CHK_HDR;
            end
         end
         S_WALK_CHK: begin
            sz = tag_size(tag_ff);
            if (sz >= need_ff) begin
               orig_in = sz;
               la_in = b_ff;
               ret_in = S_SPLIT;
               state_in = S_UL_P;
            end else begin
               mem_off = {1'b0, b_ff} + ADDR_W'(16);
               state_in = S_WALK_NEXT;
            end
         end
         S_WALK_NEXT: begin
            b_in = mem_rd;
            state_in = S_WALK;
         end

         S_SPLIT: begin
            pa_in = b_ff;
            pfree_in = 1'b0;
            state_in = S_PUT_HDR;
            if (orig_ff - need_ff >= OFF_W'(MIN_BLOCK)) begin
               psz_in = need_ff;
               ret_in = S_SPLIT_REST;
            end else begin
               psz_in = orig_ff;
               ret_in = S_ALLOC_RD;
            end
         end
         S_SPLIT_REST: begin
            pa_in = b_ff + need_ff;
            psz_in = orig_ff - need_ff;
            pfree_in = 1'b1;
            ret_in = S_SPLIT_LINK;
            state_in = S_PUT_HDR;
         end
         S_SPLIT_LINK: begin
            la_in = b_ff + need_ff;
            ret_in = S_ALLOC_RD;
            state_in = S_LK_P;
         end
         S_ALLOC_RD: begin
            mem_off = {1'b0, b_ff};
            state_in = S_ALLOC_FIN;
         end
         S_ALLOC_FIN: begin
            blocks_in = blocks_ff + 1'b1;
            used_in = used_ff + tag_size(mem_rd) - OFF_W'(OVERHEAD);
            pay_in = 16'(b_ff + OFF_W'(24));
            st_in = ST_OK;
            state_in = S_DONE;
         end

         // Heap growth by whole pages, merging with a free tail block.
         S_GROW: begin
            add_pg = (PAGE_W+1)'(({1'b0, need_ff} + ADDR_W'(PAGE_BYTES - 1)) >> PAGE_SHIFT);
            lim_b = (limit_ff > PAGE_W'(MAX_PAGES)) ? ADDR_W'(HEAP_BYTES) :
                    ADDR_W'({limit_ff, {PAGE_SHIFT{1'b0}}});
            sum_a = {1'b0, heap_end_ff} + ADDR_W'({add_pg, {PAGE_SHIFT{1'b0}}});
            if (sum_a > lim_b) begin
               fail_c = ST_EXHAUSTED;
            end else begin
               pages_in = pages_ff + add_pg[PAGE_W-1:0];
               heap_end_in = sum_a[OFF_W-1:0];
               old_in = heap_end_ff;
               grow_in = OFF_W'({add_pg, {PAGE_SHIFT{1'b0}}});
               pa_in = heap_end_ff;
               psz_in = OFF_W'({add_pg, {PAGE_SHIFT{1'b0}}});
               pfree_in = 1'b1;
               ret_in = S_GROW_RD;
               state_in = S_PUT_HDR;
            end
         end
         S_GROW_RD: begin
            if (old_ff == '0) begin
               la_in = old_ff;
               ret_in = S_GROW_DONE;
               state_in = S_LK_P;
            end else begin
               mem_off = {1'b0, old_ff} - ADDR_W'(8);
               state_in = S_GROW_TAIL;
            end
         end
         S_GROW_TAIL: begin
            sz = tag_size(mem_rd);
            if (mem_rd[0]) begin
               orig_in = sz;
               if (sz > old_ff) begin
                  fail_c = ST_CORRUPT;
               end else begin
                  ca_in = old_ff - sz;
                  ret_in = S_GROW_UNLINK;
                  state_in = S_CHK_HDR;
               end
            end else begin
               la_in = old_ff;
               ret_in = S_GROW_DONE;
               state_in = S_LK_P;
            end
         end
         S_GROW_UNLINK: begin
            la_in = old_ff - orig_ff;
            ret_in = S_GROW_PUT;
            state_in = S_UL_P;
         end
         S_GROW_PUT: begin
            pa_in = la_ff;
            psz_in = orig_ff + grow_ff;
            pfree_in = 1'b1;
            ret_in = S_GROW_LINK;
            state_in = S_PUT_HDR;
         end
         S_GROW_LINK: begin
            ret_in = S_GROW_DONE;
            state_in = S_LK_P;
         end
         S_GROW_DONE: begin
            pass_in = 1'b1;
            steps_in = '0;
            b_in = free_head_ff;
            state_in = S_WALK;
         end

         // Release with merging on both sides.
         S_REL_CHK: begin
            sz = tag_size(tag_ff);
            if (tag_ff[0]) begin
               fail_c = ST_DOUBLE;
            end else begin
               size_in = sz;
               blocks_in = blocks_ff - 1'b1;
               used_in = used_ff - (sz - OFF_W'(OVERHEAD));
               pa_in = b_ff;
               psz_in = sz;
               pfree_in = 1'b1;
               ret_in = S_REL_NEXT;
               state_in = S_PUT_HDR;
            end
         end
         S_REL_NEXT: begin
            sum_a = {1'b0, b_ff} + {1'b0, size_ff};
            if (sum_a < {1'b0, heap_end_ff}) begin
               ca_in = sum_a[OFF_W-1:0];
               ret_in = S_REL_NCHK;
               state_in = S_CHK_HDR;
            end else begin
               state_in = S_REL_PREV;
            end
         end
         S_REL_NCHK: begin
            if (tag_ff[0]) begin
               la_in = ca_ff;
               ret_in = S_REL_NRD;
               state_in = S_UL_P;
            end else begin
               state_in = S_REL_PREV;
            end
         end
         S_REL_NRD: begin
            mem_off = {1'b0, la_ff};
            state_in = S_REL_NSUM;
         end
         S_REL_NSUM: begin
            size_in = size_ff + tag_size(mem_rd);
            pa_in = b_ff;
            psz_in = size_ff + tag_size(mem_rd);
            pfree_in = 1'b1;
            ret_in = S_REL_PREV;
            state_in = S_PUT_HDR;
         end
         S_REL_PREV: begin
            if (b_ff != '0) begin
               mem_off = {1'b0, b_ff} - ADDR_W'(8);
               state_in = S_REL_PTAG;
            end else begin
               la_in = b_ff;
               ret_in = S_REL_DONE;
               state_in = S_LK_P;
            end
         end
         S_REL_PTAG: begin
            sz = tag_size(mem_rd);
            if (mem_rd[0]) begin
               orig_in = sz;
               if (sz > b_ff) begin
                  fail_c = ST_CORRUPT;
               end else begin
                  ca_in = b_ff - sz;
                  ret_in = S_REL_PUNLINK;
                  state_in = S_CHK_HDR;
               end
            end else begin
               la_in = b_ff;
               ret_in = S_REL_DONE;
               state_in = S_LK_P;
            end
         end
         S_REL_PUNLINK: begin
            b_in = b_ff - orig_ff;
            la_in = b_ff - orig_ff;
            ret_in = S_REL_PPUT;
            state_in = S_UL_P;
         end
         S_REL_PPUT: begin
            size_in = size_ff + orig_ff;
            pa_in = b_ff;
            psz_in = size_ff + orig_ff;
            pfree_in = 1'b1;
            ret_in = S_REL_LINK;
            state_in = S_PUT_HDR;
         end
         S_REL_LINK: begin
            la_in = b_ff;
            ret_in = S_REL_DONE;
            state_in = S_LK_P;
         end
         S_REL_DONE: begin
            st_in = ST_OK;
            state_in = S_DONE;
         end

         // Tag check of the block at ca; a failure ends the item.
         S_CHK_HDR: begin
            if (ca_ff >= heap_end_ff || ca_ff[3:0] != 4'd0) begin
               fail_c = ST_CORRUPT;
            end else begin
               mem_off = {1'b0, ca_ff};
               state_in = S_CHK_TAG;
            end
         end
         S_CHK_TAG: begin
            tag_in = mem_rd;
            sz = tag_size(mem_rd);
            sum_a = {1'b0, ca_ff} + {1'b0, sz};
            if (sz < OFF_W'(MIN_BLOCK) || sum_a > {1'b0, heap_end_ff}) begin
               fail_c = ST_CORRUPT;
            end else begin
               mem_off = sum_a - ADDR_W'(8);
               state_in = S_CHK_FTR;
            end
         end
         S_CHK_FTR: begin
            if (mem_rd != tag_ff) begin
               fail_c = ST_CORRUPT;
            end else begin
               state_in = ret_ff;
            end
         end

         // Unlink of the block at la.
         S_UL_P: begin
            mem_off = {1'b0, la_ff} + ADDR_W'(8);
            state_in = S_UL_N;
         end
         S_UL_N: begin
            lp_in = mem_rd;
            mem_off = {1'b0, la_ff} + ADDR_W'(16);
            state_in = S_UL_FIX;
         end
         S_UL_FIX: begin
            ln_in = mem_rd;
            if (!lp_ff[OFF_W-1]) begin
               mem_off = {1'b0, lp_ff} + ADDR_W'(16);
               mem_we = 1'b1;
               mem_wd = mem_rd;
            end else begin
               free_head_in = mem_rd;
            end
            state_in = S_UL_NFIX;
         end
         S_UL_NFIX: begin
            if (!ln_ff[OFF_W-1]) begin
               mem_off = {1'b0, ln_ff} + ADDR_W'(8);
               mem_we = 1'b1;
               mem_wd = lp_ff;
            end
            state_in = S_UL_CLRP;
         end
         S_UL_CLRP: begin
            mem_off = {1'b0, la_ff} + ADDR_W'(8);
            mem_we = 1'b1;
            mem_wd = NIL;
            state_in = S_UL_CLRN;
         end
         S_UL_CLRN: begin
            mem_off = {1'b0, la_ff} + ADDR_W'(16);
            mem_we = 1'b1;
            mem_wd = NIL;
            state_in = S_UL_RD;
         end
         S_UL_RD: begin
            mem_off = {1'b0, la_ff};
            state_in = S_UL_SUM;
         end
         S_UL_SUM: begin
            free_in = free_ff - (tag_size(mem_rd) - OFF_W'(OVERHEAD));
            state_in = ret_ff;
         end

         // Push of the block at la onto the head of the free list.
         S_LK_P: begin
            mem_off = {1'b0, la_ff} + ADDR_W'(8);
            mem_we = 1'b1;
            mem_wd = NIL;
            state_in = S_LK_N;
         end
         S_LK_N: begin
            mem_off = {1'b0, la_ff} + ADDR_W'(16);
            mem_we = 1'b1;
            mem_wd = free_head_ff;
            state_in = S_LK_HEAD;
         end
         S_LK_HEAD: begin
            if (!free_head_ff[OFF_W-1]) begin
               mem_off = {1'b0, free_head_ff} + ADDR_W'(8);
               mem_we = 1'b1;
               mem_wd = la_ff;
            end
            free_head_in = la_ff;
            state_in = S_LK_RD;
         end
         S_LK_RD: begin
            mem_off = {1'b0, la_ff};
            state_in = S_LK_SUM;
         end
         S_LK_SUM: begin
            free_in = free_ff + tag_size(mem_rd) - OFF_W'(OVERHEAD);
            state_in = ret_ff;
         end

         // Header and footer write of the block at pa.
         S_PUT_HDR: begin
            mem_off = {1'b0, pa_ff};
            mem_we = 1'b1;
            mem_wd = psz_ff | OFF_W'(pfree_ff);
            state_in = S_PUT_FTR;
         end
         S_PUT_FTR: begin
            mem_off = {1'b0, pa_ff} + {1'b0, psz_ff} - ADDR_W'(8);
            mem_we = 1'b1;
            mem_wd = psz_ff | OFF_W'(pfree_ff);
            state_in = ret_ff;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A fatal condition latches the sticky status and ends the item.
      if (fail_c != ST_OK) begin
         halt_in = fail_c;
         st_in = fail_c;
         pay_in = '0;
         state_in = S_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ret_ff <= S_IDLE;
         clr_ff <= '0;
         limit_ff <= RESET_LIMIT;
         free_head_ff <= '0;
         heap_end_ff <= OFF_W'(PAGE_BYTES);
         blocks_ff <= '0;
         used_ff <= '0;
         free_ff <= OFF_W'(PAGE_BYTES - OVERHEAD);
         pages_ff <= PAGE_W'(1);
         halt_ff <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         clr_ff <= clr_in;
         limit_ff <= limit_in;
         free_head_ff <= free_head_in;
         heap_end_ff <= heap_end_in;
         blocks_ff <= blocks_in;
         used_ff <= used_in;
         free_ff <= free_in;
         pages_ff <= pages_in;
         halt_ff <= halt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_ff <= b_in;
      size_ff <= size_in;
      need_ff <= need_in;
      orig_ff <= orig_in;
      old_ff <= old_in;
      grow_ff <= grow_in;
      steps_ff <= steps_in;
      pass_ff <= pass_in;
      ca_ff <= ca_in;
      tag_ff <= tag_in;
      la_ff <= la_in;
      lp_ff <= lp_in;
      ln_ff <= ln_in;
      pa_ff <= pa_in;
      psz_ff <= psz_in;
      pfree_ff <= pfree_in;
      st_ff <= st_in;
      pay_ff <= pay_in;
      rsp_data_ff <= rsp_data_in;
      oob_ff <= !mem_hit;
   end
endmodule

>>> rtl/bthal_checker.sv
module bthal_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic        csr_wen,
   input logic [4:0]  csr_wdata
);
   import bthal_pkg::*;

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_err_no_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != ST_OK |-> rsp_tdata[18:3] == 16'd0)
      else $error("payload offset on a failed item");

   a_payload_align: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[18:3] != 16'd0 |-> rsp_tdata[6:3] == 4'd8)
      else $error("payload offset not 8 modulo 16");

   a_pages: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[70:66] != 5'd0 && rsp_tdata[70:66] <= 5'(MAX_PAGES))
      else $error("pages mapped out of range");
endmodule

bind boundary_tag_heap_allocator bthal_checker u_bthal_checker (.*);
